/* hdl/pst_pkg.sv */
// Shared types and constants for the periodic task scheduler table.
// Used by pst_ctrl, pst_dp and periodic_task_scheduler_table; no dependencies.
package pst_pkg;

  localparam int TABLE_DEPTH_DEF = 8;
  localparam int ID_W            = 8;
  localparam int TICK_W          = 32;
  localparam int HELD_W          = 4;

  typedef enum logic [2:0] {
    KIND_TICK   = 3'd0,
    KIND_ADD    = 3'd1,
    KIND_REMOVE = 3'd2,
    KIND_SET_EN = 3'd3,
    KIND_RUN    = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECODE,
    ST_SRCH_RD,
    ST_SRCH_EV,
    ST_ADD_WR,
    ST_SET_WR,
    ST_REM_RD,
    ST_REM_WR,
    ST_RUN_RD,
    ST_RUN_EV,
    ST_RUN_END,
    ST_RESP
  } state_t;

  typedef enum logic [1:0] {
    WR_ADD,
    WR_SET,
    WR_SHIFT,
    WR_RUN
  } wr_sel_t;

  typedef enum logic [1:0] {
    EMIT_NONE,
    EMIT_RESP,
    EMIT_MID,
    EMIT_FINAL
  } emit_t;

  typedef struct packed {
    logic [ID_W-1:0]   id;
    logic [TICK_W-1:0] period;
    logic [TICK_W-1:0] next_run;
    logic              enabled;
  } entry_t;

  typedef struct packed {
    logic    accept;
    logic    tick_inc;
    logic    idx_clr;
    logic    idx_inc;
    logic    rd_en;
    logic    rd_next;
    logic    wr_en;
    wr_sel_t wr_sel;
    logic    count_inc;
    logic    count_dec;
    logic    ok_set;
    logic    pend_load;
    emit_t   emit;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    logic  id_zero;
    logic  count_zero;
    logic  full;
    logic  match;
    logic  due;
    logic  last_idx;
    logic  pend_valid;
    logic  out_free;
  } status_t;

endpackage

/* hdl/pst_ctrl.sv */
// Controller state machine for the periodic task scheduler table.
// Depends on pst_pkg; drives pst_dp through command and status structs.
module pst_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  pst_pkg::status_t st,
  output pst_pkg::cmd_t    cmd
);

  pst_pkg::state_t state;
  pst_pkg::state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pst_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    cmd.wr_sel = pst_pkg::WR_ADD;
    cmd.emit   = pst_pkg::EMIT_NONE;
    unique case (state)
      pst_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_next = pst_pkg::ST_DECODE;
        end
      end
      pst_pkg::ST_DECODE: begin
        cmd.idx_clr = 1'b1;
        unique case (st.kind)
          pst_pkg::KIND_TICK: begin
            cmd.tick_inc = 1'b1;
            state_next   = pst_pkg::ST_RESP;
          end
          pst_pkg::KIND_ADD: begin
            if (st.full || st.id_zero) begin
              state_next = pst_pkg::ST_RESP;
            end else if (st.count_zero) begin
              state_next = pst_pkg::ST_ADD_WR;
            end else begin
              state_next = pst_pkg::ST_SRCH_RD;
            end
          end
          pst_pkg::KIND_REMOVE, pst_pkg::KIND_SET_EN: begin
            if (st.id_zero || st.count_zero) begin
              state_next = pst_pkg::ST_RESP;
            end else begin
              state_next = pst_pkg::ST_SRCH_RD;
            end
          end
          pst_pkg::KIND_RUN: begin
            if (st.count_zero) begin
              state_next = pst_pkg::ST_RESP;
            end else begin
              state_next = pst_pkg::ST_RUN_RD;
            end
          end
          default: begin
            state_next = pst_pkg::ST_RESP;
          end
        endcase
      end
      pst_pkg::ST_SRCH_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = pst_pkg::ST_SRCH_EV;
      end
      pst_pkg::ST_SRCH_EV: begin
        if (st.match) begin
          unique case (st.kind)
            pst_pkg::KIND_SET_EN: state_next = pst_pkg::ST_SET_WR;
            pst_pkg::KIND_REMOVE: state_next = pst_pkg::ST_REM_RD;
            default:              state_next = pst_pkg::ST_RESP;
          endcase
        end else if (st.last_idx) begin
          if (st.kind == pst_pkg::KIND_ADD) begin
            state_next = pst_pkg::ST_ADD_WR;
          end else begin
            state_next = pst_pkg::ST_RESP;
          end
        end else begin
          cmd.idx_inc = 1'b1;
          state_next  = pst_pkg::ST_SRCH_RD;
        end
      end
      pst_pkg::ST_ADD_WR: begin
        cmd.wr_en     = 1'b1;
        cmd.wr_sel    = pst_pkg::WR_ADD;
        cmd.count_inc = 1'b1;
        cmd.ok_set    = 1'b1;
        state_next    = pst_pkg::ST_RESP;
      end
      pst_pkg::ST_SET_WR: begin
        cmd.wr_en  = 1'b1;
        cmd.wr_sel = pst_pkg::WR_SET;
        cmd.ok_set = 1'b1;
        state_next = pst_pkg::ST_RESP;
      end
      pst_pkg::ST_REM_RD: begin
        if (st.last_idx) begin
          cmd.count_dec = 1'b1;
          cmd.ok_set    = 1'b1;
          state_next    = pst_pkg::ST_RESP;
        end else begin
          cmd.rd_en   = 1'b1;
          cmd.rd_next = 1'b1;
          state_next  = pst_pkg::ST_REM_WR;
        end
      end
      pst_pkg::ST_REM_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_sel  = pst_pkg::WR_SHIFT;
        cmd.idx_inc = 1'b1;
        state_next  = pst_pkg::ST_REM_RD;
      end
      pst_pkg::ST_RUN_RD: begin
        cmd.rd_en  = 1'b1;
        state_next = pst_pkg::ST_RUN_EV;
      end
      pst_pkg::ST_RUN_EV: begin
        if (!(st.due && st.pend_valid && !st.out_free)) begin
          if (st.due) begin
            cmd.wr_en     = 1'b1;
            cmd.wr_sel    = pst_pkg::WR_RUN;
            cmd.pend_load = 1'b1;
            if (st.pend_valid) begin
              cmd.emit = pst_pkg::EMIT_MID;
            end
          end
          if (st.last_idx) begin
            state_next = pst_pkg::ST_RUN_END;
          end else begin
            cmd.idx_inc = 1'b1;
            state_next  = pst_pkg::ST_RUN_RD;
          end
        end
      end
      pst_pkg::ST_RUN_END: begin
        if (st.out_free) begin
          cmd.emit   = pst_pkg::EMIT_FINAL;
          state_next = pst_pkg::ST_IDLE;
        end
      end
      pst_pkg::ST_RESP: begin
        if (st.out_free) begin
          cmd.emit   = pst_pkg::EMIT_RESP;
          state_next = pst_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pst_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

/* hdl/pst_dp.sv */
// Datapath of the periodic task scheduler table: item registers, task memory,
// tick and fill counters, pending dispatch and output register. Depends on pst_pkg.
module pst_dp #(
  parameter int TABLE_DEPTH = pst_pkg::TABLE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [79:0]      in_data,
  input  logic [2:0]       in_user,
  input  logic             out_ready,
  output logic             out_valid,
  output logic [47:0]      out_data,
  output logic             out_last,
  input  pst_pkg::cmd_t    cmd,
  output pst_pkg::status_t st
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  pst_pkg::entry_t mem [TABLE_DEPTH];
  pst_pkg::entry_t rd_q;
  pst_pkg::entry_t wr_data;
  logic [IDX_W-1:0] wr_addr;
  logic [IDX_W-1:0] rd_addr;

  pst_pkg::kind_t              item_kind;
  logic [pst_pkg::ID_W-1:0]    item_id;
  logic [pst_pkg::TICK_W-1:0]  item_period;
  logic [pst_pkg::TICK_W-1:0]  item_offset;
  logic                        item_en;

  logic [pst_pkg::TICK_W-1:0]  tick;
  logic [CNT_W-1:0]            count;
  logic [IDX_W-1:0]            idx;
  logic [CNT_W-1:0]            idx_p1;
  logic                        ok;
  logic                        pend_valid;
  logic [pst_pkg::ID_W-1:0]    pend_id;
  logic                        overdue;
  logic [pst_pkg::TICK_W-1:0]  resched;
  logic                        out_free;

  assign idx_p1   = CNT_W'(idx) + CNT_W'(1);
  assign overdue  = rd_q.next_run <= tick;
  assign resched  = tick + rd_q.period;
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_kind   <= pst_pkg::kind_t'(in_user);
      item_id     <= in_data[7:0];
      item_period <= in_data[39:8];
      item_offset <= in_data[71:40];
      item_en     <= in_data[72];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tick       <= '0;
      count      <= '0;
      ok         <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      if (cmd.tick_inc) begin
        tick <= tick + pst_pkg::TICK_W'(1);
      end
      if (cmd.count_inc) begin
        count <= count + CNT_W'(1);
      end else if (cmd.count_dec) begin
        count <= count - CNT_W'(1);
      end
      if (cmd.accept) begin
        ok         <= 1'b0;
        pend_valid <= 1'b0;
      end else begin
        if (cmd.ok_set) begin
          ok <= 1'b1;
        end
        if (cmd.pend_load) begin
          pend_valid <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idx_clr) begin
      idx <= '0;
    end else if (cmd.idx_inc) begin
      idx <= idx + IDX_W'(1);
    end
    if (cmd.pend_load) begin
      pend_id <= rd_q.id;
    end
  end

  assign rd_addr = cmd.rd_next ? idx_p1[IDX_W-1:0] : idx;

  always_comb begin
    wr_addr = idx;
    wr_data = rd_q;
    case (cmd.wr_sel)
      pst_pkg::WR_ADD: begin
        wr_addr          = count[IDX_W-1:0];
        wr_data.id       = item_id;
        wr_data.period   = item_period;
        wr_data.next_run = item_offset;
        wr_data.enabled  = 1'b1;
      end
      pst_pkg::WR_SET: begin
        wr_data.enabled = item_en;
        if (item_en && overdue) begin
          wr_data.next_run = resched;
        end
      end
      pst_pkg::WR_RUN: begin
        wr_data.next_run = resched;
      end
      default: begin
        wr_data = rd_q;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit != pst_pkg::EMIT_NONE) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit != pst_pkg::EMIT_NONE) begin
      out_data[41:10] <= tick;
      out_data[45:42] <= pst_pkg::HELD_W'(count);
      out_data[47:46] <= 2'b00;
      if (cmd.emit == pst_pkg::EMIT_MID ||
          (cmd.emit == pst_pkg::EMIT_FINAL && pend_valid)) begin
        out_data[7:0] <= pend_id;
        out_data[8]   <= 1'b1;
        out_data[9]   <= 1'b0;
        out_last      <= cmd.emit == pst_pkg::EMIT_FINAL;
      end else begin
        out_data[7:0] <= '0;
        out_data[8]   <= 1'b0;
        out_data[9]   <= ok;
        out_last      <= 1'b1;
      end
    end
  end

  always_comb begin
    st            = '0;
    st.kind       = item_kind;
    st.id_zero    = item_id == '0;
    st.count_zero = count == '0;
    st.full       = count == CNT_W'(TABLE_DEPTH);
    st.match      = rd_q.id == item_id;
    st.due        = rd_q.enabled && overdue;
    st.last_idx   = idx_p1 == count;
    st.pend_valid = pend_valid;
    st.out_free   = out_free;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("task count above table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && count != $past(count) |->
      (count == $past(count) + CNT_W'(1) || count == $past(count) - CNT_W'(1)))
    else $error("task count moved by more than one");

  a_tick_step: assert property (@(posedge clk) disable iff (rst)
    !$past(rst) && tick != $past(tick) |-> tick == $past(tick) + pst_pkg::TICK_W'(1))
    else $error("tick count jumped");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit != pst_pkg::EMIT_NONE |-> out_free)
    else $error("result beat overwrote a waiting beat");

endmodule

/* hdl/periodic_task_scheduler_table.sv */
// Periodic task scheduler table, top level. Tick and rejected items go from decode straight
// to the result state. Add/remove/set enable search the table entry by entry over the
// single-port task memory; remove shifts later entries down; run scans every entry, one
// result beat per due task (one if none is due), a waiting beat stalls the scan. One item
// in flight; the next is taken while the last result beat waits. Reset clears the tick and
// task counts; table entries are not cleared, only entries below the count are read.
module periodic_task_scheduler_table #(
  parameter int TABLE_DEPTH = pst_pkg::TABLE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,   // task_id[7:0], period[39:8], start_offset[71:40],
                                 // enable_flag[72], zero[79:73]
  input  logic [2:0]  s_tuser,   // kind[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,   // fired_task[7:0], fired[8], ok[9], tick_now[41:10],
                                 // tasks_held[45:42], zero[47:46]
  output logic        m_tlast    // last
);

  pst_pkg::cmd_t    cmd;
  pst_pkg::status_t st;

  pst_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  pst_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (s_tdata),
    .in_user   (s_tuser),
    .out_ready (m_tready),
    .out_valid (m_tvalid),
    .out_data  (m_tdata),
    .out_last  (m_tlast),
    .cmd       (cmd),
    .st        (st)
  );

endmodule
